FILE: design/ppgm_pkg.sv
package ppgm_pkg;

	localparam int TS_W         = 32;
	localparam int HOLD_W       = 24;
	localparam int SPR_W        = 5;
	localparam int LEN_W        = 14;
	localparam int PERIOD_WIDTH = 24;
	localparam int MAX_SAMPLES  = 16;
	localparam int SUM_W        = 28;
	localparam int AVG_W        = 28;
	localparam int DEN_W        = 2 * AVG_W;
	localparam int G_W          = 46;
	localparam int NUM_W        = G_W + LEN_W;
	localparam int GRAV_W       = 32;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int FIFO_DEPTH   = 2;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int ITER_W       = 5;

	// 4 * pi^2 scaled so that L in mm and T in us give g in mm/s^2.
	localparam logic [G_W-1:0] G_SCALE = 46'd39478400000000;

	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd2;

	localparam logic [HOLD_W-1:0] HOLDOFF_RST = 24'd100000;
	localparam logic [SPR_W-1:0]  SAMPLES_RST = 5'd10;
	localparam logic [LEN_W-1:0]  LENGTH_RST  = 14'd500;

	// One closed period handed from the front to the back.
	typedef struct packed {
		logic [PERIOD_WIDTH-1:0] period;
		logic [SPR_W-1:0]        sample;
		logic                    fin;
		logic [SUM_W-1:0]        sum;
		logic [SPR_W-1:0]        n;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AVG,
		B_SQR,
		B_MUL,
		B_CHK,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

FILE: design/ppgm_front.sv
module ppgm_front import ppgm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [TS_W-1:0]   timestamp_us,
	input  logic [HOLD_W-1:0] holdoff_us,
	input  logic [SPR_W-1:0]  samples_per_result,
	output logic              job_push,
	output job_t              job
);

	logic [TS_W-1:0]  last_q;
	logic [TS_W-1:0]  start_q;
	logic [1:0]       pass_q;
	logic [SUM_W-1:0] sum_q;
	logic [SPR_W-1:0] done_q;

	logic [TS_W-1:0]  delta;
	logic [TS_W-1:0]  raw_period;
	logic             pass_ok;
	logic [SPR_W-1:0] n_eff;
	logic [SPR_W-1:0] done_next;
	logic [SUM_W-1:0] sum_next;

	always_comb begin
		delta      = timestamp_us - last_q;
		pass_ok    = delta > {{(TS_W-HOLD_W){1'b0}}, holdoff_us};
		raw_period = timestamp_us - start_q;
		if (samples_per_result == '0) begin
			n_eff = SPR_W'(1);
		end else if (samples_per_result > SPR_W'(MAX_SAMPLES)) begin
			n_eff = SPR_W'(MAX_SAMPLES);
		end else begin
			n_eff = samples_per_result;
		end
		done_next = done_q + SPR_W'(1);

		if (raw_period[TS_W-1:PERIOD_WIDTH] != '0) begin
			job.period = '1;
		end else begin
			job.period = raw_period[PERIOD_WIDTH-1:0];
		end
		sum_next   = sum_q + SUM_W'(job.period);
		job.sample = done_next;
		job.fin    = done_next >= n_eff;
		job.sum    = sum_next;
		job.n      = n_eff;
		job_push   = accept && pass_ok && (pass_q == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			start_q <= '0;
			pass_q  <= '0;
			sum_q   <= '0;
			done_q  <= '0;
		end else if (accept && pass_ok) begin
			last_q <= timestamp_us;
			case (pass_q)
				2'd0: begin
					start_q <= timestamp_us;
					pass_q  <= 2'd1;
				end
				2'd1: begin
					pass_q <= 2'd2;
				end
				default: begin
					pass_q <= 2'd0;
					if (job.fin) begin
						sum_q  <= '0;
						done_q <= '0;
					end else begin
						sum_q  <= sum_next;
						done_q <= done_next;
					end
				end
			endcase
		end
	end

endmodule

FILE: design/ppgm_fifo.sv
module ppgm_fifo import ppgm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output job_t rdata,
	output logic empty
);

	job_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + FIFO_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond its depth");

endmodule

FILE: design/ppgm_back.sv
module ppgm_back import ppgm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	input  job_t                    job,
	output logic                    job_pop,
	input  logic [LEN_W-1:0]        string_length_mm,
	output logic                    empty,
	input  logic                    pop,
	output logic [PERIOD_WIDTH-1:0] period_us,
	output logic [SPR_W-1:0]        sample_number,
	output logic                    final_res,
	output logic [PERIOD_WIDTH-1:0] average_period_us,
	output logic [GRAV_W-1:0]       gravity_milli
);

	back_state_t state_q, state_d;

	logic [PERIOD_WIDTH-1:0] jper_q;
	logic [SPR_W-1:0]        jsmp_q;
	logic                    jfin_q;
	logic [SPR_W-1:0]        n_q;
	logic [ITER_W-1:0]       it_q;
	logic [SPR_W-1:0]        ra_q;
	logic [SUM_W-1:0]        qs_q;
	logic [DEN_W-1:0]        den_q;
	logic [NUM_W-1:0]        num_q;
	logic [LEN_W-1:0]        lsh_q;
	logic [DEN_W-1:0]        rem_q;
	logic [GRAV_W-1:0]       nsh_q;
	logic                    ov_q;

	logic [SPR_W:0]   ra_r2;
	logic             ra_ge;
	logic [SPR_W:0]   ra_diff;
	logic [DEN_W-1:0] sq;
	logic             g_sat;
	logic [DEN_W:0]   dv_r2;
	logic             dv_ge;
	logic [DEN_W:0]   dv_diff;
	logic             out_free;
	logic             load_out;

	always_comb begin
		ra_r2   = {ra_q, qs_q[SUM_W-1]};
		ra_ge   = ra_r2 >= {1'b0, n_q};
		ra_diff = ra_r2 - {1'b0, n_q};
		sq      = qs_q * qs_q;
		g_sat   = {{(DEN_W+GRAV_W-NUM_W){1'b0}}, num_q} >= {den_q, {GRAV_W{1'b0}}};
		dv_r2   = {rem_q, nsh_q[GRAV_W-1]};
		dv_ge   = dv_r2 >= {1'b0, den_q};
		dv_diff = dv_r2 - {1'b0, den_q};
		out_free = !ov_q || pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = job.fin ? B_AVG : B_OUT;
				end
			end
			B_AVG: begin
				if (it_q == '0) begin
					state_d = B_SQR;
				end
			end
			B_SQR: begin
				state_d = (qs_q == '0) ? B_OUT : B_MUL;
			end
			B_MUL: begin
				if (it_q == '0) begin
					state_d = B_CHK;
				end
			end
			B_CHK: begin
				state_d = g_sat ? B_OUT : B_DIV;
			end
			B_DIV: begin
				if (it_q == '0) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Working registers: the quotient of the average builds up in qs_q, the
	// gravity quotient in nsh_q.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				jper_q <= job.period;
				jsmp_q <= job.sample;
				jfin_q <= job.fin;
				n_q    <= job.n;
				qs_q   <= job.sum;
				ra_q   <= '0;
				nsh_q  <= '0;
				it_q   <= ITER_W'(SUM_W - 1);
			end
			B_AVG: begin
				ra_q <= ra_ge ? ra_diff[SPR_W-1:0] : ra_r2[SPR_W-1:0];
				qs_q <= {qs_q[SUM_W-2:0], ra_ge};
				it_q <= it_q - ITER_W'(1);
			end
			B_SQR: begin
				den_q <= sq;
				num_q <= '0;
				lsh_q <= string_length_mm;
				it_q  <= ITER_W'(LEN_W - 1);
				if (qs_q == '0) begin
					nsh_q <= '1;
				end
			end
			B_MUL: begin
				num_q <= {num_q[NUM_W-2:0], 1'b0}
					+ (lsh_q[LEN_W-1] ? NUM_W'(G_SCALE) : NUM_W'(0));
				lsh_q <= {lsh_q[LEN_W-2:0], 1'b0};
				it_q  <= it_q - ITER_W'(1);
			end
			B_CHK: begin
				rem_q <= DEN_W'(num_q[NUM_W-1:GRAV_W]);
				nsh_q <= g_sat ? '1 : num_q[GRAV_W-1:0];
				it_q  <= ITER_W'(GRAV_W - 1);
			end
			B_DIV: begin
				rem_q <= dv_ge ? dv_diff[DEN_W-1:0] : dv_r2[DEN_W-1:0];
				nsh_q <= {nsh_q[GRAV_W-2:0], dv_ge};
				it_q  <= it_q - ITER_W'(1);
			end
			default: begin
				it_q <= it_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_out) begin
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			period_us         <= jper_q;
			sample_number     <= jsmp_q;
			final_res         <= jfin_q;
			average_period_us <= jfin_q ? qs_q[PERIOD_WIDTH-1:0] : '0;
			gravity_milli     <= jfin_q ? nsh_q : '0;
		end
	end

	assign empty = !ov_q;

	a_partial_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !final_res) |-> (average_period_us == '0 && gravity_milli == '0))
		else $error("partial result carries average or gravity");

	a_avg_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_AVG) |-> ({1'b0, ra_q} < {1'b0, n_q}))
		else $error("average remainder not below the count");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (rem_q < den_q))
		else $error("gravity remainder not below the divisor");

endmodule

FILE: design/pendulum_period_gravity_meter_top.sv
// Pendulum period and gravity meter.
//
// Input side: one beat per falling edge of the pendulum sensor, carrying its
// free-running microsecond timestamp. A beat is taken when push is high and
// full is low. Edges that fall within the holdoff of the last accepted edge
// are dropped silently; every third accepted edge closes one period.
// Result side: one beat per closed period, presented while empty is low and
// taken when pop is high. The beat that completes an average also carries
// the truncated mean period and gravity in thousandths of m/s^2.
// Configuration: cfg_we, cfg_index and cfg_wdata write holdoff, periods per
// average and string length; write them only while the block is idle.
// A plain period result passes the queue, the back end and its output
// register. A final result also runs through the serial averaging divider
// (28 steps), the shift-add length multiplier (14 steps) and the restoring
// gravity divider (32 steps) in the back end. Edges are accepted every cycle
// while the two-entry queue between front and back has room.
// Reset clears all timing state, the queue and the output valid flag, and
// restores the register defaults. When the receiver stalls, the result is
// held, the back end waits, the queue fills and full is raised.
module pendulum_period_gravity_meter_top import ppgm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [TS_W-1:0]         timestamp_us,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	output logic                    empty,
	input  logic                    pop,
	output logic [PERIOD_WIDTH-1:0] period_us,
	output logic [SPR_W-1:0]        sample_number,
	output logic                    final_res,
	output logic [PERIOD_WIDTH-1:0] average_period_us,
	output logic [GRAV_W-1:0]       gravity_milli
);

	logic [HOLD_W-1:0] holdoff_q;
	logic [SPR_W-1:0]  samples_q;
	logic [LEN_W-1:0]  length_q;

	logic accept;
	logic job_push;
	logic job_pop;
	logic fifo_empty;
	job_t job_in;
	job_t job_out;

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q <= HOLDOFF_RST;
			samples_q <= SAMPLES_RST;
			length_q  <= LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOLDOFF: holdoff_q <= cfg_wdata[HOLD_W-1:0];
				REG_SAMPLES: samples_q <= cfg_wdata[SPR_W-1:0];
				REG_LENGTH:  length_q  <= cfg_wdata[LEN_W-1:0];
				default:     holdoff_q <= holdoff_q;
			endcase
		end
	end

	// The front only takes an edge when the queue can hold whatever it makes.
	assign accept = push && !full;

	ppgm_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.timestamp_us       (timestamp_us),
		.holdoff_us         (holdoff_q),
		.samples_per_result (samples_q),
		.job_push           (job_push),
		.job                (job_in)
	);

	ppgm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (fifo_empty)
	);

	ppgm_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.job_valid         (!fifo_empty),
		.job               (job_out),
		.job_pop           (job_pop),
		.string_length_mm  (length_q),
		.empty             (empty),
		.pop               (pop),
		.period_us         (period_us),
		.sample_number     (sample_number),
		.final_res         (final_res),
		.average_period_us (average_period_us),
		.gravity_milli     (gravity_milli)
	);

endmodule
